### rtl/kcl_pkg.sv
// kcl_pkg: shared types and constants for the keypad code lock
// no dependencies
`default_nettype none

package kcl_pkg;

  localparam int TICK_W = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_CODE_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_SYMBOLS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_WRONG = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INPUT_TIMEOUT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNLOCK_HOLD = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT = 3'd5;

  localparam logic ACT_KEY = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  typedef enum logic [1:0] {
    MODE_IDLE     = 2'd0,
    MODE_ENTERING = 2'd1,
    MODE_UNLOCKED = 2'd2,
    MODE_LOCKED   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    NOTE_NONE    = 3'd0,
    NOTE_KEY     = 3'd1,
    NOTE_OK      = 3'd2,
    NOTE_FAIL    = 3'd3,
    NOTE_LOCKOUT = 3'd4,
    NOTE_IDLE    = 3'd5
  } notice_t;

  typedef struct packed {
    logic [3:0]        code_length;
    logic [31:0]       code_symbols;
    logic [3:0]        max_wrong_attempts;
    logic [TICK_W-1:0] input_timeout_ticks;
    logic [TICK_W-1:0] unlock_hold_ticks;
    logic [TICK_W-1:0] lockout_ticks;
  } kcl_cfg_t;

  typedef struct packed {
    notice_t           notice;
    mode_t             lock_state;
    logic [3:0]        wrong_attempts;
    logic [3:0]        entered_count;
    logic [TICK_W-1:0] remain_ticks;
  } kcl_result_t;

endpackage

`default_nettype wire

### rtl/keypad_code_lock_with_lockout_core.sv
// keypad code lock top level: config registers, result pipeline, seconds divide
// depends on kcl_pkg and kcl_fsm
// pipeline: an input's result is registered in s1 and then in s2, which drives the outputs
// throughput: one item per cycle while out_ready does not stall the output; state updates
//   at transfer, the tick-to-second constant multiply sits in the second stage
// reset: synchronous; state idle, counters zero, config at defaults, pipeline empty
`default_nettype none

module keypad_code_lock_with_lockout_core
  import kcl_pkg::*;
#(
  parameter int MAX_CODE_LEN = 8,
  parameter int SYMBOL_BITS = 4,
  parameter int TICKS_PER_SECOND = 100
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_wen,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  action,
  input  wire logic [3:0]            symbol,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [2:0]                 notice,
  output logic [1:0]                 lock_state,
  output logic [3:0]                 wrong_attempts,
  output logic [3:0]                 entered_count,
  output logic [15:0]                lockout_seconds_left
);

  localparam int DIV_SHIFT = TICK_W + $clog2(TICKS_PER_SECOND);
  localparam logic [TICK_W:0] DIV_MULT =
    (TICK_W + 1)'(((64'd1 << DIV_SHIFT) + TICKS_PER_SECOND - 1) / TICKS_PER_SECOND);

  kcl_cfg_t    cfg;
  kcl_result_t fsm_res;
  kcl_result_t s1;
  logic        s1_valid;
  kcl_result_t s2;
  logic [15:0] s2_seconds;
  logic        s2_load;
  logic        accept;
  logic [2*TICK_W:0] prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.code_length <= 4'd4;
      cfg.code_symbols <= 32'd0;
      cfg.max_wrong_attempts <= 4'd3;
      cfg.input_timeout_ticks <= 16'd300;
      cfg.unlock_hold_ticks <= 16'd500;
      cfg.lockout_ticks <= 16'd30000;
    end else if (cfg_wen) begin
      case (cfg_index)
        CFG_CODE_LENGTH:   cfg.code_length <= cfg_data[3:0];
        CFG_CODE_SYMBOLS:  cfg.code_symbols <= cfg_data;
        CFG_MAX_WRONG:     cfg.max_wrong_attempts <= cfg_data[3:0];
        CFG_INPUT_TIMEOUT: cfg.input_timeout_ticks <= cfg_data[TICK_W-1:0];
        CFG_UNLOCK_HOLD:   cfg.unlock_hold_ticks <= cfg_data[TICK_W-1:0];
        CFG_LOCKOUT:       cfg.lockout_ticks <= cfg_data[TICK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign s2_load = !out_valid || out_ready;
  assign in_ready = !s1_valid || s2_load;
  assign accept = in_valid && in_ready;

  kcl_fsm #(
    .MAX_CODE_LEN(MAX_CODE_LEN),
    .SYMBOL_BITS (SYMBOL_BITS)
  ) u_fsm (
    .clk   (clk),
    .rst   (rst),
    .step  (accept),
    .action(action),
    .symbol(symbol),
    .cfg   (cfg),
    .res   (fsm_res)
  );

  // divide by ticks per second as multiply by rounded-up reciprocal
  assign prod = (2 * TICK_W + 1)'(s1.remain_ticks) * (2 * TICK_W + 1)'(DIV_MULT);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (s2_load) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= fsm_res;
    end
    if (s2_load && s1_valid) begin
      s2 <= s1;
      s2_seconds <= 16'(prod >> DIV_SHIFT);
    end
  end

  assign notice = s2.notice;
  assign lock_state = s2.lock_state;
  assign wrong_attempts = s2.wrong_attempts;
  assign entered_count = s2.entered_count;
  assign lockout_seconds_left = s2_seconds;

endmodule

`default_nettype wire

### rtl/kcl_fsm.sv
// kcl_fsm: lock state machine, entry buffer, counters and code compare
// depends on kcl_pkg
`default_nettype none

module kcl_fsm
  import kcl_pkg::*;
#(
  parameter int MAX_CODE_LEN = 8,
  parameter int SYMBOL_BITS = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        step,
  input  wire logic        action,
  input  wire logic [3:0]  symbol,
  input  wire kcl_cfg_t    cfg,
  output kcl_result_t      res
);

  localparam int FILL_W = $clog2(MAX_CODE_LEN + 1);
  localparam int IDX_W = (MAX_CODE_LEN > 1) ? $clog2(MAX_CODE_LEN) : 1;
  localparam int CMP_W = (FILL_W > 4) ? FILL_W : 4;
  localparam int PAD_W = MAX_CODE_LEN * SYMBOL_BITS + 32;
  localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

  mode_t                  mode, mode_next;
  logic [SYMBOL_BITS-1:0] store [MAX_CODE_LEN];
  logic [FILL_W-1:0]      fill, fill_next;
  logic [TICK_W-1:0]      idle_ticks, idle_next;
  logic [TICK_W-1:0]      hold_ticks, hold_next;
  logic [3:0]             fail, fail_next;
  notice_t                note;
  logic                   wr_en;

  logic [SYMBOL_BITS-1:0] sym;
  logic [TICK_W-1:0]      idle_inc, hold_inc;
  logic [3:0]             fail_inc;
  logic                   has_room;
  logic [PAD_W-1:0]       code_pad;
  logic [MAX_CODE_LEN-1:0] lane_ok;
  logic                   match;

  assign sym = SYMBOL_BITS'(symbol);
  assign idle_inc = (idle_ticks == TICK_MAX) ? idle_ticks : idle_ticks + 1'b1;
  assign hold_inc = (hold_ticks == TICK_MAX) ? hold_ticks : hold_ticks + 1'b1;
  assign fail_inc = (fail == 4'hf) ? fail : fail + 1'b1;
  assign has_room = fill < FILL_W'(MAX_CODE_LEN);
  assign code_pad = PAD_W'(cfg.code_symbols);

  // per-slot compare, slots past the fill are don't care
  for (genvar i = 0; i < MAX_CODE_LEN; i++) begin : g_lane
    assign lane_ok[i] = (FILL_W'(i) >= fill) ||
                        (store[i] == code_pad[SYMBOL_BITS*i +: SYMBOL_BITS]);
  end

  assign match = (CMP_W'(fill) == CMP_W'(cfg.code_length)) && (fill != '0) && (&lane_ok);

  always_comb begin
    mode_next = mode;
    fill_next = fill;
    idle_next = idle_ticks;
    hold_next = hold_ticks;
    fail_next = fail;
    note = NOTE_NONE;
    wr_en = 1'b0;
    if (action == ACT_KEY) begin
      if (mode == MODE_IDLE || mode == MODE_ENTERING) begin
        mode_next = MODE_ENTERING;
        if (has_room) begin
          wr_en = 1'b1;
          fill_next = fill + 1'b1;
        end
        idle_next = '0;
        note = NOTE_KEY;
      end
    end else begin
      case (mode)
        MODE_ENTERING: begin
          idle_next = idle_inc;
          if (idle_inc >= cfg.input_timeout_ticks) begin
            fill_next = '0;
            idle_next = '0;
            if (match) begin
              mode_next = MODE_UNLOCKED;
              fail_next = '0;
              hold_next = '0;
              note = NOTE_OK;
            end else begin
              fail_next = fail_inc;
              if (fail_inc >= cfg.max_wrong_attempts) begin
                mode_next = MODE_LOCKED;
                hold_next = '0;
                note = NOTE_LOCKOUT;
              end else begin
                mode_next = MODE_IDLE;
                note = NOTE_FAIL;
              end
            end
          end
        end
        MODE_UNLOCKED: begin
          hold_next = hold_inc;
          if (hold_inc >= cfg.unlock_hold_ticks) begin
            mode_next = MODE_IDLE;
            note = NOTE_IDLE;
          end
        end
        MODE_LOCKED: begin
          hold_next = hold_inc;
          if (hold_inc >= cfg.lockout_ticks) begin
            mode_next = MODE_IDLE;
            fail_next = '0;
            note = NOTE_IDLE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    res.notice = note;
    res.lock_state = mode_next;
    res.wrong_attempts = fail_next;
    res.entered_count = 4'(fill_next);
    if (mode_next == MODE_LOCKED && hold_next < cfg.lockout_ticks) begin
      res.remain_ticks = cfg.lockout_ticks - hold_next;
    end else begin
      res.remain_ticks = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_IDLE;
      fill <= '0;
      idle_ticks <= '0;
      hold_ticks <= '0;
      fail <= '0;
    end else if (step) begin
      mode <= mode_next;
      fill <= fill_next;
      idle_ticks <= idle_next;
      hold_ticks <= hold_next;
      fail <= fail_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step && wr_en) begin
      store[fill[IDX_W-1:0]] <= sym;
    end
  end

endmodule

`default_nettype wire
